// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the sliding window median unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clock while reset is low.
`define SWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante, while reset is low.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/swm_pkg.sv -----
// Package with the constants and types of the sliding window median unit.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int SLOT_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int CFG_BITS    = 7;

   localparam logic [CFG_BITS-1:0] LENGTH_RESET = CFG_BITS'(3);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SLOT_BITS-1:0]          slot_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic [CFG_BITS-1:0]           cfg_type;

   // One sorted entry: the sample and the ring slot it arrived in.
   typedef struct packed {
      sample_type value;
      slot_type   age;
   } entry_type;

   // What a cell shows its right-hand neighbour about its present contents.
   typedef struct packed {
      entry_type entry;
      logic      ins;    // new sample goes at or before this place
      logic      after;  // entry sorts at or after the sample being dropped
   } cell_link_type;

   // Broadcast from the control to every cell.
   typedef struct packed {
      sample_type key;
      slot_type   key_age;
      sample_type drop_value;
      logic       shift;  // a beat is taken this cycle
      logic       drop;   // the oldest sample leaves in the same cycle
   } cell_ctrl_type;

endpackage

// ----- rtl/swm_cell.sv -----
// One cell of the sorted window row: holds one entry, inserts and drops in place.
`timescale 1ns / 1ps

module swm_cell (
   input  logic                   clock,
   input  swm_pkg::cell_ctrl_type ctrl,
   input  logic                   valid,
   input  swm_pkg::cell_link_type left_link,
   input  swm_pkg::entry_type     right_entry,
   output swm_pkg::cell_link_type own_link,
   output swm_pkg::entry_type     prime_entry
);

   swm_pkg::sample_type value_ff;
   swm_pkg::sample_type value_in;
   swm_pkg::slot_type   age_ff;
   swm_pkg::slot_type   age_in;
   logic                prime_after;
   logic                key_after;

   assign key_after = $signed(ctrl.key) >= $signed(ctrl.drop_value);

   always_comb begin
      own_link.entry.value = value_ff;
      own_link.entry.age   = age_ff;
      own_link.ins         = !valid || ($signed(value_ff) > $signed(ctrl.key));
      own_link.after       = valid && ($signed(value_ff) >= $signed(ctrl.drop_value));
   end

   // Contents of this place once the new sample has been inserted.
   always_comb begin
      if (left_link.ins) begin
         prime_entry = left_link.entry;
         prime_after = left_link.after;
      end else if (own_link.ins) begin
         prime_entry.value = ctrl.key;
         prime_entry.age   = ctrl.key_age;
         prime_after       = key_after;
      end else begin
         prime_entry = own_link.entry;
         prime_after = own_link.after;
      end
   end

   // When the oldest sample leaves, every place at or past it pulls from the right.
   always_comb begin
      if (ctrl.drop && prime_after) begin
         value_in = right_entry.value;
         age_in   = right_entry.age;
      end else begin
         value_in = prime_entry.value;
         age_in   = prime_entry.age;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

// ----- rtl/sliding_window_median_unit.sv -----
// Top level of the sliding window median unit: control, cell row and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A median is registered and is on rsp_median in the cycle after the beat that completes its window.
// Throughput: one sample beat per cycle; the cell row inserts the new sample and drops
// the oldest one in the same cycle, so nothing but a stalled result register holds it up.
// Reset (synchronous, active high) empties the window, sets the length to three and
// clears the result valid flag; the cell contents and the median value need no reset.

module sliding_window_median_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [swm_pkg::CFG_BITS-1:0]       csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [swm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [swm_pkg::SAMPLE_BITS-1:0] rsp_median
);

   localparam int MaxWindow = swm_pkg::MAX_WINDOW;

   // Configured length as written, and the length actually used.
   swm_pkg::cfg_type    len_ff;
   swm_pkg::cfg_type    len_in;
   swm_pkg::count_type  len_act;
   swm_pkg::count_type  len_m1;
   swm_pkg::slot_type   median_sel;

   // Window bookkeeping: samples held and the next ring slot.
   swm_pkg::count_type  fill_ff;
   swm_pkg::count_type  fill_in;
   swm_pkg::slot_type   write_slot_ff;
   swm_pkg::slot_type   write_slot_in;
   swm_pkg::slot_type   oldest_slot;
   swm_pkg::count_type  oldest_wide;

   logic                req_accept;
   logic                full;

   // Result register between the cell row and the output channel.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   swm_pkg::sample_type rsp_median_ff;
   swm_pkg::sample_type rsp_median_in;

   // Cell row wiring.
   swm_pkg::cell_ctrl_type ctrl;
   swm_pkg::cell_link_type own_link_w   [MaxWindow];
   swm_pkg::cell_link_type left_link_w  [MaxWindow];
   swm_pkg::entry_type     prime_w      [MaxWindow];
   swm_pkg::entry_type     right_entry_w[MaxWindow];
   logic [MaxWindow-1:0]   valid_vec;
   logic [MaxWindow-1:0]   match_vec;
   swm_pkg::sample_type    drop_value;

   // A new beat may come in whenever the result register is free or being emptied.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // A length of zero behaves as one, and anything above the row length as the row length.
   always_comb begin
      if (len_ff == '0) begin
         len_act = swm_pkg::count_type'(1);
      end else if (int'(len_ff) > MaxWindow) begin
         len_act = swm_pkg::count_type'(MaxWindow);
      end else begin
         len_act = swm_pkg::count_type'(len_ff);
      end
      len_m1     = len_act - swm_pkg::count_type'(1);
      median_sel = swm_pkg::slot_type'(len_m1 >> 1);
   end

   // The window is complete once this beat arrives when it already holds length-1 samples.
   assign full = fill_ff >= len_m1;

   // The oldest sample sits fill_ff slots behind the write slot, modulo the ring size.
   always_comb begin
      if (swm_pkg::count_type'(write_slot_ff) >= fill_ff) begin
         oldest_wide = swm_pkg::count_type'(write_slot_ff) - fill_ff;
      end else begin
         oldest_wide = swm_pkg::count_type'(write_slot_ff)
                     + swm_pkg::count_type'(MaxWindow) - fill_ff;
      end
      oldest_slot = swm_pkg::slot_type'(oldest_wide);
   end

   // Valid places form a prefix of the row, fill_ff long.
   always_comb begin
      for (int i = 0; i < MaxWindow; i++) begin
         valid_vec[i] = swm_pkg::count_type'(i) < fill_ff;
         match_vec[i] = valid_vec[i] && (own_link_w[i].entry.age == oldest_slot);
      end
   end

   // At most one place holds the oldest slot, so an AND-OR picks its value.
   always_comb begin
      drop_value = '0;
      for (int i = 0; i < MaxWindow; i++) begin
         drop_value = drop_value
                    | (own_link_w[i].entry.value & {swm_pkg::SAMPLE_BITS{match_vec[i]}});
      end
   end

   always_comb begin
      ctrl.key        = req_sample;
      ctrl.key_age    = write_slot_ff;
      ctrl.drop_value = drop_value;
      ctrl.shift      = req_accept;
      ctrl.drop       = full;
   end

   for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_link_w[i] = '0;
      end else begin : g_inner
         assign left_link_w[i] = own_link_w[i-1];
      end
      if (i == MaxWindow - 1) begin : g_last
         assign right_entry_w[i] = '0;
      end else begin : g_body
         assign right_entry_w[i] = prime_w[i+1];
      end

      swm_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .valid       (valid_vec[i]),
         .left_link   (left_link_w[i]),
         .right_entry (right_entry_w[i]),
         .own_link    (own_link_w[i]),
         .prime_entry (prime_w[i])
      );
   end

   // Length register and window bookkeeping. A length write or a final beat empties
   // the window; otherwise a beat grows it until it holds one sample less than the length.
   always_comb begin
      len_in        = len_ff;
      fill_in       = fill_ff;
      write_slot_in = write_slot_ff;
      if (csr_wr_en) begin
         len_in        = csr_wr_data;
         fill_in       = '0;
         write_slot_in = '0;
      end else if (req_accept) begin
         if (req_last_sample) begin
            fill_in       = '0;
            write_slot_in = '0;
         end else begin
            if (!full) begin
               fill_in = fill_ff + swm_pkg::count_type'(1);
            end
            if (write_slot_ff == swm_pkg::slot_type'(MaxWindow - 1)) begin
               write_slot_in = '0;
            end else begin
               write_slot_in = write_slot_ff + swm_pkg::slot_type'(1);
            end
         end
      end
   end

   // The median is read at the lower middle place of the window after insertion, before the drop.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in  = req_accept && full;
         rsp_median_in = prime_w[median_sel].value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= swm_pkg::LENGTH_RESET;
         fill_ff       <= '0;
         write_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         fill_ff       <= fill_in;
         write_slot_ff <= write_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   // The window never holds a whole length between beats.
   `SWM_ASSERT(a_fill_below_length, fill_ff < len_act, "window holds too many samples")
   // Ring slots in the window are distinct.
   `SWM_ASSERT(a_oldest_unique, $onehot0(match_vec), "oldest slot found in several places")
   // With a length above one the oldest sample is present whenever a window completes.
   `SWM_ASSERT(a_oldest_present, (req_accept && full && (len_act != swm_pkg::count_type'(1)))
      |-> $onehot(match_vec), "oldest sample missing from the row")
   // A completing beat always leaves a result behind.
   `SWM_ASSERT_NEXT(a_result_follows, req_accept && full, rsp_valid_ff,
      "completed window gave no result")

endmodule

// ----- tb/sliding_window_median_unit_tb.sv -----
// Self-checking testbench for the sliding window median unit, with its own median predictor.
`timescale 1ns / 1ps

module sliding_window_median_unit_tb;

   import swm_pkg::*;

   // The sample extremes, built at the width that the package gives.
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   // A median appears in the cycle after its beat; these spare cycles give margin for that.
   localparam int SETTLE_CYCLES   = 8;
   // Length of the one long hold-off of the result channel, in cycles.
   localparam int HOLD_OFF_CYCLES = 300;
   // Random beats aimed for after the directed part.
   localparam int LARGE_WINDOW_BEATS = 90;
   localparam int RANDOM_BEATS       = 860;
   localparam int PRESSURE_BEATS     = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   cfg_type    csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   sample_type req_sample;
   logic       req_last_sample;
   logic       rsp_valid;
   logic       rsp_stall;
   sample_type rsp_median;

   sliding_window_median_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median      (rsp_median)
   );

   // Clock with a period of 4 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The predictor's copy of the block: the programmed length, the window in
   // arrival order, and the same samples kept in ascending order. Equal values
   // sit in arrival order, older first, exactly as the block keeps them.
   cfg_type    length_reg;
   sample_type arrival_window[$];
   sample_type sorted_window[$];
   sample_type expected_medians[$];

   int error_count  = 0;
   int burst_left   = 0;
   bit pacing_on    = 1'b1;
   bit hold_off_req = 1'b0;

   // The length that the block actually uses: zero acts as one, and anything
   // beyond the store depth acts as the full depth.
   function automatic int effective_length(cfg_type value);
      if (value == '0)
         return 1;
      if (int'(value) > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(value);
   endfunction

   function automatic void empty_window();
      arrival_window.delete();
      sorted_window.delete();
   endfunction

   // Works out what one accepted sample beat does to the window, and queues
   // the median if the beat completes a full window.
   function automatic void median_window_step(sample_type sample, logic last);
      int         len;
      int         pos;
      sample_type oldest;
      len = effective_length(length_reg);
      if (arrival_window.size() >= len)
         empty_window();
      arrival_window.push_back(sample);
      // Insert after every entry that is not greater, so that ties keep arrival order.
      pos = 0;
      while (pos < sorted_window.size() && sorted_window[pos] <= sample)
         pos++;
      sorted_window.insert(pos, sample);
      if (arrival_window.size() >= len) begin
         expected_medians.push_back(sorted_window[(len - 1) / 2]);
         // The oldest sample leaves. Among equal values it is the first one in
         // sorted order, since ties are kept oldest first.
         oldest = arrival_window.pop_front();
         pos = 0;
         while (pos < sorted_window.size() && sorted_window[pos] != oldest)
            pos++;
         sorted_window.delete(pos);
      end
      if (last)
         empty_window();
   endfunction

   // Sample values: mostly full-range random words, so that every bit takes
   // both values, with a good share of small values to force ties, and some
   // values hugging the two extremes.
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return sample_type'($urandom);
         4, 5:       return sample_type'(int'($urandom_range(0, 7)) - 4);
         6:          return sample_type'(SAMPLE_MIN + $urandom_range(0, 3));
         default:    return sample_type'(SAMPLE_MAX - $urandom_range(0, 3));
      endcase
   endfunction

   // The end-of-sequence flag is rare next to the window length, so that most
   // sequences run long enough to fill the window and slide.
   function automatic logic pick_last();
      return $urandom_range(0, 3 * effective_length(length_reg) + 4) == 0;
   endfunction

   // The sender works in bursts: after each burst the valid drops for a few
   // cycles. Now and then a long burst gives a stretch with no gaps at all.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Offers one sample beat and holds it steady until the block takes it.
   // The valid stays high afterwards, so that back-to-back beats need no
   // second assignment in one time step.
   task automatic send_sample(sample_type sample, logic last);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      median_window_step(sample, last);
      if (pacing_on)
         pace_sender();
   endtask

   // Stops offering beats and waits until every queued median has come out,
   // then a few cycles more, since a beat that gave no median may still be
   // working its way through.
   task automatic wait_for_medians();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_medians.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the window length while the block is idle. Any write empties the window.
   task automatic program_window_length(cfg_type value);
      wait_for_medians();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      length_reg = value;
      empty_window();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // The length after reset is three, so no write is made first. The first
   // window holds both extremes and zero; a sequence that ends before the
   // window is full must give no median at all.
   task automatic test_default_length();
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd5, 1'b1);
      send_sample(32'sd7, 1'b0);
      send_sample(32'sd8, 1'b1);
   endtask

   // With a length of one every sample is its own median.
   task automatic test_length_one();
      program_window_length(cfg_type'(1));
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(sample_type'(32'h5555_5555), 1'b0);
      send_sample(sample_type'(32'hAAAA_AAAA), 1'b0);
   endtask

   // A length of zero must behave as a length of one.
   task automatic test_length_zero();
      program_window_length(cfg_type'(0));
      send_sample(32'sd42, 1'b0);
      send_sample(-32'sd42, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
   endtask

   // An even length gives the lower median; repeated values check that ties
   // leave the window in arrival order.
   task automatic test_even_length_ties();
      program_window_length(cfg_type'(4));
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(-32'sd3, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd9, 1'b1);
   endtask

   // A length write in the middle of a partly filled window throws the
   // partial window away: the next median comes from new samples only.
   task automatic test_length_change();
      program_window_length(cfg_type'(5));
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      program_window_length(cfg_type'(2));
      send_sample(-32'sd10, 1'b0);
      send_sample(32'sd10, 1'b0);
   endtask

   // The full store depth, and lengths beyond it that must be clipped to it,
   // among them the all-ones register value.
   task automatic test_large_windows();
      cfg_type lengths[4];
      lengths = '{cfg_type'(64), cfg_type'(127), cfg_type'(65), cfg_type'(64)};
      foreach (lengths[k]) begin
         program_window_length(lengths[k]);
         repeat (LARGE_WINDOW_BEATS)
            send_sample(pick_sample(), pick_last());
      end
   endtask

   // Phases of random length, mostly short windows so that sequences fill
   // and slide often, with the odd long or out-of-range length in between.
   task automatic test_random_lengths();
      int      sent;
      int      phase_beats;
      cfg_type value;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 19))
            0, 1:    value = cfg_type'($urandom_range(0, 127));
            2, 3, 4: value = cfg_type'($urandom_range(10, 64));
            default: value = cfg_type'($urandom_range(1, 9));
         endcase
         program_window_length(value);
         phase_beats = $urandom_range(20, 60);
         repeat (phase_beats)
            send_sample(pick_sample(), pick_last());
         sent += phase_beats;
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering beats back to back, so that the result register fills and the
   // block has to stall its input.
   task automatic test_backpressure();
      program_window_length(cfg_type'(3));
      @(posedge clock);
      hold_off_req = 1'b1;
      pacing_on    = 1'b0;
      repeat (PRESSURE_BEATS)
         send_sample(pick_sample(), $urandom_range(0, 15) == 0);
      pacing_on = 1'b1;
   endtask

   // Receiver: stalls on a 16-bit pattern that is drawn afresh each time it
   // runs out. Some patterns are clear, to give stretches with no stalls, and
   // some are solid. A hold-off request overrides the pattern for the length
   // of the hold-off, counted here.
   initial begin : result_receiver
      logic [15:0] pattern;
      int          phase;
      int          hold_left;
      pattern   = '0;
      phase     = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (phase == 0) begin
            case ($urandom_range(0, 7))
               0, 1:    pattern = '0;
               2:       pattern = '1;
               3, 4:    pattern = 16'($urandom) & 16'($urandom);
               default: pattern = 16'($urandom);
            endcase
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= pattern[phase];
         end
         phase = (phase + 1) % 16;
      end
   end

   // Checks every accepted result beat against the oldest median still due.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_medians.size() == 0) begin
            $error("median: expected none, got %0d", rsp_median);
            error_count++;
         end else begin
            if (rsp_median !== expected_medians[0]) begin
               $error("median: expected %0d, got %0d", expected_medians[0], rsp_median);
               error_count++;
            end
            void'(expected_medians.pop_front());
         end
      end
   end

   // Stimulus: reset once, the directed tests, then the random ones, then a
   // drain of everything still due before the verdict.
   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_last_sample = 1'b0;
      length_reg      = LENGTH_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_length();
      test_length_one();
      test_length_zero();
      test_even_length_ties();
      test_length_change();
      test_large_windows();
      test_random_lengths();
      test_backpressure();

      wait_for_medians();
      if (expected_medians.size() != 0) begin
         $error("median: %0d results never arrived", expected_medians.size());
         error_count++;
      end
      if (error_count == 0)
         $display("sliding_window_median_unit_tb: clean");
      else
         $display("sliding_window_median_unit_tb: errors");
      $finish;
   end

   // Watchdog: a correct run finishes far inside this time.
   initial begin
      #2_000_000;
      $display("sliding_window_median_unit_tb: errors");
      $finish;
   end

endmodule

// ----- sliding_window_median_unit.f -----
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_median_unit.sv
tb/sliding_window_median_unit_tb.sv
